/* hdl/kbks_pkg.sv */
`default_nettype none
package kbks_pkg;
  localparam int KEY_W = 53;
  localparam logic [1:0] OP_BASE = 2'd0;
  localparam logic [1:0] OP_HASH = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] CFG_KMER = 2'd0;
  localparam logic [1:0] CFG_ENTRIES = 2'd1;
  localparam logic [1:0] CFG_SEED = 2'd2;
  localparam logic [1:0] CFG_DOUBLE = 2'd3;
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef logic [KEY_W-1:0] key_t;

  function automatic logic [63:0] seed_of(input logic [1:0] code);
    logic [63:0] r;
    case (code)
      2'd0: r = 64'h3c8bfbb395c60474;
      2'd1: r = 64'h3193c18562a02b4c;
      2'd2: r = 64'h295549f54be24456;
      default: r = 64'h20323ed082572324;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] n);
    return (x << n) | (x >> (7'd64 - {1'b0, n}));
  endfunction
endpackage
`default_nettype wire

/* hdl/kbks_fmix.sv */
`default_nettype none
// Seeded fmix64, one or two rounds, one operation per cycle with a 32x32 style
// partial-product multiply split into four partial products per 64-bit product.
module kbks_fmix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  input  wire logic        two_rounds_i,
  input  wire logic [63:0] seed_i,
  output logic             done_o,
  output logic [63:0]      result_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_XS   = 4'd3;
  localparam logic [3:0] S_DONE = 4'd4;

  logic [3:0]  state_q, state_d;
  logic [63:0] h_q, h_d, acc_q, acc_d;
  logic [1:0]  part_q, part_d;
  logic        second_mul_q, second_mul_d;
  logic        more_q, more_d;
  logic [63:0] mul_c;
  logic [31:0] a_part, b_part;
  logic [63:0] prod;
  logic [63:0] prod_sh;

  assign mul_c  = second_mul_q ? kbks_pkg::FMIX_C2 : kbks_pkg::FMIX_C1;
  assign a_part = part_q[0] ? h_q[63:32] : h_q[31:0];
  assign b_part = part_q[1] ? mul_c[63:32] : mul_c[31:0];
  assign prod   = {32'd0, a_part} * {32'd0, b_part};
  always_comb begin
    case (part_q)
      2'd0: prod_sh = prod;
      2'd1, 2'd2: prod_sh = {prod[31:0], 32'd0};
      default: prod_sh = 64'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    h_d = h_q;
    acc_d = acc_q;
    part_d = part_q;
    second_mul_d = second_mul_q;
    more_d = more_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          h_d = value_i;
          more_d = two_rounds_i;
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        h_d = (h_q ^ seed_i) ^ ((h_q ^ seed_i) >> 33);
        acc_d = 64'd0;
        part_d = 2'd0;
        second_mul_d = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        acc_d = acc_q + prod_sh;
        part_d = part_q + 2'd1;
        if (part_q == 2'd3) state_d = S_XS;
      end
      S_XS: begin
        h_d = acc_q ^ (acc_q >> 33);
        acc_d = 64'd0;
        part_d = 2'd0;
        if (!second_mul_q) begin
          second_mul_d = 1'b1;
          state_d = S_MUL;
        end else if (more_q) begin
          more_d = 1'b0;
          state_d = S_PRE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    acc_q <= acc_d;
    part_q <= part_d;
    second_mul_q <= second_mul_d;
    more_q <= more_d;
  end

  assign done_o = (state_q == S_DONE);
  assign result_o = h_q;
endmodule
`default_nettype wire

/* hdl/kbks_store.sv */
`default_nettype none
// Sorted key store in one synchronous memory. Insertion scans for the slot,
// then ripples entries up one place per read/write pair.
module kbks_store #(
  parameter int MAX_ENTRIES = 1024,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ins_i,
  input  wire logic          rd_i,
  input  wire logic          fit_i,
  input  wire kbks_pkg::key_t key_i,
  input  wire logic [AW-1:0] idx_i,
  input  wire logic [CW-1:0] limit_i,
  output logic               done_o,
  output logic               inserted_o,
  output logic               entry_valid_o,
  output kbks_pkg::key_t     entry_o,
  output logic [CW-1:0]      count_o,
  output kbks_pkg::key_t     cutoff_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_CUT   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  kbks_pkg::key_t mem [MAX_ENTRIES];
  kbks_pkg::key_t rdata_q;
  logic [AW-1:0]  raddr;
  logic           re, we;
  logic [AW-1:0]  waddr;
  kbks_pkg::key_t wdata;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d, pos_q, pos_d;
  kbks_pkg::key_t cutoff_q, cutoff_d, key_q, key_d, carry_q, carry_d;
  logic           ins_q, ins_d, ev_q, ev_d, cutrd_q, cutrd_d;
  logic           full;
  logic [CW-1:0]  last;

  assign full = (count_q >= limit_i);
  assign last = full ? limit_i - CW'(1) : count_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q; count_d = count_q; pos_d = pos_q; cutoff_d = cutoff_q;
    key_d = key_q; carry_d = carry_q; ins_d = ins_q;
    ev_d = ev_q; cutrd_d = 1'b0;
    re = 1'b0; raddr = pos_q[AW-1:0];
    we = 1'b0; waddr = pos_q[AW-1:0]; wdata = carry_q;
    case (state_q)
      S_IDLE: begin
        if (ins_i) begin
          key_d = key_i; ins_d = 1'b0; pos_d = '0;
          if (full && key_i >= cutoff_q) state_d = S_DONE;
          else if (count_q == '0) begin
            we = 1'b1; waddr = '0; wdata = key_i; ins_d = 1'b1;
            count_d = CW'(1);
            state_d = S_CUT;
          end else begin
            re = 1'b1; raddr = '0; state_d = S_SCAN;
          end
        end else if (rd_i) begin
          ev_d = ({1'b0, idx_i} < {1'b0, count_q});
          re = 1'b1; raddr = idx_i; state_d = S_READ;
        end else if (fit_i) begin
          if (count_q > limit_i) count_d = limit_i;
          state_d = S_CUT;
        end
      end
      S_SCAN: begin
        // rdata_q holds mem[pos_q]
        if (rdata_q == key_q) state_d = S_DONE;
        else if (rdata_q > key_q) begin
          carry_d = rdata_q; we = 1'b1; wdata = key_q; ins_d = 1'b1;
          if (!full) count_d = count_q + CW'(1);
          if (pos_q + CW'(1) > last) state_d = S_CUT;
          else begin
            pos_d = pos_q + CW'(1); re = 1'b1; raddr = pos_d[AW-1:0];
            state_d = S_SHIFT;
          end
        end else if (pos_q + CW'(1) >= count_q) begin
          if (full) state_d = S_DONE;
          else begin
            we = 1'b1; waddr = count_q[AW-1:0]; wdata = key_q; ins_d = 1'b1;
            count_d = count_q + CW'(1); state_d = S_CUT;
          end
        end else begin
          pos_d = pos_q + CW'(1); re = 1'b1; raddr = pos_d[AW-1:0];
        end
      end
      S_SHIFT: begin
        // write carried key at pos_q, carry the old one upward
        we = 1'b1; wdata = carry_q;
        if (pos_q < count_q - (full ? CW'(0) : CW'(1))) carry_d = rdata_q;
        if (pos_q >= last) state_d = S_CUT;
        else begin
          pos_d = pos_q + CW'(1); re = 1'b1; raddr = pos_d[AW-1:0];
        end
      end
      S_CUT: begin
        // fetch the top entry to refresh the cutoff
        if (!cutrd_q && count_q == limit_i) begin
          re = 1'b1; raddr = AW'(limit_i - CW'(1)); cutrd_d = 1'b1;
        end else begin
          if (cutrd_q) cutoff_d = rdata_q;
          state_d = S_DONE;
        end
      end
      S_READ: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; cutoff_q <= '0;
      cutrd_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; cutoff_q <= cutoff_d;
      cutrd_q <= cutrd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; key_q <= key_d; carry_q <= carry_d; ins_q <= ins_d; ev_q <= ev_d;
  end

  assign done_o = (state_q == S_DONE);
  assign inserted_o = ins_q;
  assign entry_valid_o = ev_q;
  assign entry_o = ev_q ? rdata_q : '0;
  assign count_o = count_q;
  assign cutoff_o = cutoff_q;
endmodule
`default_nettype wire

/* hdl/kmer_bottom_k_sketch.sv */
`default_nettype none
// Bottom-k k-mer sketch. Each word carries one base, one hash or one read
// request and yields one result word. The ntHash rolls on each base; a key
// then passes through a seeded fmix unit that works on four-part 64-bit
// products, and a sorted insertion into a memory with one read and one write
// port that scans and shifts one entry per cycle; once the sketch is full, a
// key at or above the cutoff is rejected without a scan. No clearing pass is
// needed after reset.
module kmer_bottom_k_sketch #(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_KMER = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic        last_in_sequence_i,
  input  wire logic [63:0] hash_value_i,
  input  wire logic [9:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             key_valid_o,
  output logic [52:0]      key_o,
  output logic             inserted_o,
  output logic [10:0]      fill_count_o,
  output logic             sketch_full_o,
  output logic [52:0]      cutoff_key_o,
  output logic             entry_valid_o,
  output logic [52:0]      entry_value_o
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = $clog2(MAX_KMER + 1);
  localparam int WW = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_FMIX = 3'd1;
  localparam logic [2:0] T_STORE = 3'd2;
  localparam logic [2:0] T_OUT = 3'd3;
  localparam logic [2:0] T_FIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] kmer_q;
  logic [CW-1:0] limit_q;
  logic [63:0] seed_q;
  logic dbl_q;
  logic [63:0] fwd_q, rev_q;
  logic [2:0] win_q [MAX_KMER];
  logic [KW-1:0] seen_q;
  logic [KW-1:0] bad_q;

  logic fm_start, fm_two, fm_done;
  logic fm_busy_q;
  logic [63:0] fm_val, fm_res;
  logic st_ins, st_rd, st_fit, st_done, st_insd, st_ev;
  kbks_pkg::key_t st_entry, st_cut;
  logic [CW-1:0] st_count;

  logic keyv_q, ins_q, ev_q, st_rd_q;
  kbks_pkg::key_t key_q, entry_q;
  logic [63:0] hpend_q;
  logic two_q;

  // config with saturation
  logic [5:0] kmer_sat;
  logic [10:0] lim_raw;
  logic [CW-1:0] lim_sat;
  always_comb begin
    kmer_sat = (cfg_data_i[5:0] == 6'd0) ? 6'd1 : cfg_data_i[5:0];
    if (32'(kmer_sat) > MAX_KMER) kmer_sat = 6'(MAX_KMER);
    lim_raw = cfg_data_i[10:0];
    if (lim_raw < 11'd2) lim_raw = 11'd2;
    if (32'(lim_raw) > MAX_ENTRIES) lim_sat = CW'(MAX_ENTRIES);
    else lim_sat = CW'(lim_raw);
  end

  // base encoding and rolling hash
  logic [7:0] cu;
  logic bad;
  logic [1:0] e, oe;
  logic [2:0] o;
  logic full_win;
  logic [63:0] fwd_n, rev_n, hmin;
  logic [KW-1:0] bad_n, seen_n;
  logic emit;
  always_comb begin
    cu = base_char_i & kbks_pkg::CASE_MASK;
    bad = !(cu == "A" || cu == "C" || cu == "G" || cu == "T");
    e = bad ? 2'd0 : base_char_i[2:1];
    full_win = ({{(32-KW){1'b0}}, seen_q} >= 32'(kmer_q));
    o = win_q[WW'(kmer_q - 6'd1)];
    oe = o[1:0];
    bad_n = bad_q;
    seen_n = seen_q;
    if (full_win) begin
      if (o[2] && bad_q != '0) bad_n = bad_q - KW'(1);
      fwd_n = kbks_pkg::rotl(fwd_q, 6'd1) ^ kbks_pkg::rotl(kbks_pkg::seed_of(oe), kmer_q)
            ^ kbks_pkg::seed_of(e);
      rev_n = kbks_pkg::rotl(rev_q, 6'd63) ^ kbks_pkg::rotl(kbks_pkg::seed_of(oe ^ 2'd2), 6'd63)
            ^ kbks_pkg::rotl(kbks_pkg::seed_of(e ^ 2'd2), kmer_q - 6'd1);
    end else begin
      fwd_n = kbks_pkg::rotl(fwd_q, 6'd1) ^ kbks_pkg::seed_of(e);
      rev_n = rev_q ^ kbks_pkg::rotl(kbks_pkg::seed_of(e ^ 2'd2), 6'(seen_q));
      seen_n = seen_q + KW'(1);
    end
    if (bad) bad_n = bad_n + KW'(1);
    emit = ({{(32-KW){1'b0}}, seen_n} >= 32'(kmer_q)) && (bad_n == '0);
    hmin = (fwd_n < rev_n) ? fwd_n : rev_n;
  end

  logic accept;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == T_IDLE);

  // fit requests produce no output word
  logic fit_q;

  always_comb begin
    state_d = state_q;
    fm_start = 1'b0; fm_val = hpend_q; fm_two = two_q;
    st_ins = 1'b0; st_rd = 1'b0; st_fit = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          case (opcode_i)
            kbks_pkg::OP_BASE: state_d = emit ? T_FMIX : T_OUT;
            kbks_pkg::OP_HASH: state_d = T_FMIX;
            kbks_pkg::OP_READ: begin st_rd = 1'b1; state_d = T_STORE; end
            default: state_d = T_OUT;
          endcase
        end else if (cfg_we_i && cfg_index_i == kbks_pkg::CFG_ENTRIES) begin
          state_d = T_FIT;
        end
      end
      T_FIT: begin st_fit = 1'b1; state_d = T_STORE; end
      T_FMIX: begin
        fm_start = 1'b1;
        if (fm_done) begin st_ins = 1'b1; state_d = T_STORE; end
      end
      T_STORE: if (st_done) state_d = fit_q ? T_IDLE : T_OUT;
      T_OUT: if (out_ready_i) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == T_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE; kmer_q <= 6'(21 > MAX_KMER ? MAX_KMER : 21);
      limit_q <= CW'(MAX_ENTRIES < 1024 ? MAX_ENTRIES : 1024);
      seed_q <= '0; dbl_q <= 1'b1; fwd_q <= '0; rev_q <= '0;
      seen_q <= '0; bad_q <= '0; fit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_FIT) fit_q <= 1'b1;
      else if (state_q == T_IDLE) fit_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          kbks_pkg::CFG_KMER: begin
            kmer_q <= kmer_sat; fwd_q <= '0; rev_q <= '0; seen_q <= '0; bad_q <= '0;
          end
          kbks_pkg::CFG_ENTRIES: limit_q <= lim_sat;
          kbks_pkg::CFG_SEED: seed_q <= cfg_data_i;
          default: dbl_q <= cfg_data_i[0];
        endcase
      end
      if (accept && opcode_i == kbks_pkg::OP_BASE) begin
        if (last_in_sequence_i) begin
          fwd_q <= '0; rev_q <= '0; seen_q <= '0; bad_q <= '0;
        end else begin
          fwd_q <= fwd_n; rev_q <= rev_n; seen_q <= seen_n; bad_q <= bad_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keyv_q <= (opcode_i == kbks_pkg::OP_HASH) ||
                (opcode_i == kbks_pkg::OP_BASE && emit);
      ev_q <= 1'b0;
      hpend_q <= (opcode_i == kbks_pkg::OP_HASH) ? hash_value_i : hmin;
      two_q <= (opcode_i == kbks_pkg::OP_BASE) && dbl_q;
      key_q <= '0;
      if (opcode_i == kbks_pkg::OP_BASE) begin
        for (int i = MAX_KMER - 1; i > 0; i--) win_q[i] <= win_q[i-1];
        win_q[0] <= {bad, e};
      end
    end
    if (state_q == T_FMIX && fm_done) key_q <= fm_res[63:11];
    if (state_q == T_STORE && st_done) ev_q <= st_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) st_rd_q <= (opcode_i == kbks_pkg::OP_READ);
  end

  kbks_fmix u_fmix (
    .clk_i, .rst_ni,
    .start_i(fm_start && !fm_busy_q),
    .value_i(fm_val),
    .two_rounds_i(fm_two),
    .seed_i(seed_q),
    .done_o(fm_done),
    .result_o(fm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fm_busy_q <= 1'b0;
    else if (fm_done) fm_busy_q <= 1'b0;
    else if (fm_start) fm_busy_q <= 1'b1;
  end

  kbks_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
    .clk_i, .rst_ni,
    .ins_i(st_ins), .rd_i(st_rd), .fit_i(st_fit),
    .key_i(fm_res[63:11]),
    .idx_i(AW'(entry_index_i)),
    .limit_i(limit_q),
    .done_o(st_done), .inserted_o(st_insd), .entry_valid_o(st_ev),
    .entry_o(st_entry), .count_o(st_count), .cutoff_o(st_cut)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == T_STORE && st_done) begin
      ins_q <= keyv_q && st_insd;
      entry_q <= st_entry;
    end
    if (accept) ins_q <= 1'b0;
    if (accept) entry_q <= '0;
  end

  assign key_valid_o = keyv_q;
  assign key_o = keyv_q ? key_q : '0;
  assign inserted_o = ins_q;
  assign fill_count_o = 11'(st_count);
  assign sketch_full_o = (st_count == limit_q);
  assign cutoff_key_o = sketch_full_o ? st_cut : '0;
  assign entry_valid_o = st_ev && ev_q;
  assign entry_value_o = (st_ev && ev_q) ? entry_q : '0;
endmodule
`default_nettype wire

/* verif/tb_top.sv */
module tb_top;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic           key_valid;
    kbks_pkg::key_t key;
    logic           inserted;
    logic [10:0]    fill_count;
    logic           sketch_full;
    kbks_pkg::key_t cutoff_key;
    logic           entry_valid;
    kbks_pkg::key_t entry_value;
  } sketch_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic        last;
    logic [63:0] hash;
    logic [9:0]  idx;
    logic        typed;
    sketch_res_t res;
  } stim_row_t;

  localparam logic [63:0] ROLL_SEED [4] = '{64'h3c8bfbb395c60474, 64'h3193c18562a02b4c,
                                            64'h295549f54be24456, 64'h20323ed082572324};

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  opcode_i;
  logic [7:0]  base_char_i;
  logic        last_in_sequence_i;
  logic [63:0] hash_value_i;
  logic [9:0]  entry_index_i;
  logic        out_valid_o, out_ready_i;
  logic        key_valid_o, inserted_o, sketch_full_o, entry_valid_o;
  logic [52:0] key_o, cutoff_key_o, entry_value_o;
  logic [10:0] fill_count_o;

  kmer_bottom_k_sketch dut (.*);

  // Predictor state
  int unsigned    win_len, keep_count, double_fmix;
  logic [63:0]    fmix_seed;
  kbks_pkg::key_t kept_keys [1024];
  int unsigned    kept_n;
  kbks_pkg::key_t kept_cutoff;
  logic [63:0]    fwd_h, rev_h;
  logic [2:0]     bases [32];
  int unsigned    seen_n, bad_n;

  sketch_res_t expected_words[$];
  logic        typed_pending;
  sketch_res_t typed_word;
  int          tx_idle, rx_idle;
  int          mismatches;
  int          wd_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rot_left(logic [63:0] x, int unsigned n);
    n = n & 63;
    if (n == 0) return x;
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic logic [63:0] seeded_fmix(logic [63:0] h);
    h = h ^ fmix_seed;
    h = h ^ (h >> 33);
    h = h * kbks_pkg::FMIX_C1;
    h = h ^ (h >> 33);
    h = h * kbks_pkg::FMIX_C2;
    h = h ^ (h >> 33);
    return h;
  endfunction

  function automatic void restart_rolling();
    fwd_h = '0;
    rev_h = '0;
    seen_n = 0;
    bad_n = 0;
  endfunction

  function automatic logic add_key(kbks_pkg::key_t k);
    int unsigned pos, i;
    logic        full;
    pos = 0;
    full = (kept_n >= keep_count);
    if (full && k >= kept_cutoff) return 1'b0;
    while (pos < kept_n && kept_keys[pos] < k) pos++;
    if (pos < kept_n && kept_keys[pos] == k) return 1'b0;
    i = full ? keep_count - 1 : kept_n;
    while (i > pos) begin
      kept_keys[i] = kept_keys[i-1];
      i--;
    end
    kept_keys[pos] = k;
    if (!full) kept_n++;
    if (kept_n == keep_count) kept_cutoff = kept_keys[keep_count-1];
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [63:0] v);
    int unsigned n;
    case (idx)
      kbks_pkg::CFG_KMER: begin
        n = 32'(v[5:0]);
        win_len = (n < 1) ? 1 : (n > 32) ? 32 : n;
        restart_rolling();
      end
      kbks_pkg::CFG_ENTRIES: begin
        n = 32'(v[10:0]);
        keep_count = (n < 2) ? 2 : (n > 1024) ? 1024 : n;
        if (kept_n > keep_count) kept_n = keep_count;
        if (kept_n == keep_count) kept_cutoff = kept_keys[keep_count-1];
      end
      kbks_pkg::CFG_SEED: fmix_seed = v;
      kbks_pkg::CFG_DOUBLE: double_fmix = 32'(v[0]);
      default: ;
    endcase
  endfunction

  function automatic sketch_res_t sketch_step(logic [1:0] op, logic [7:0] ch, logic last,
                                              logic [63:0] hv, logic [9:0] idx);
    sketch_res_t r;
    logic        bad;
    logic [7:0]  cu;
    logic [1:0]  code, old_code;
    logic [2:0]  old;
    logic [63:0] h;
    r = '0;
    if (op == kbks_pkg::OP_BASE) begin
      cu = ch & kbks_pkg::CASE_MASK;
      bad = !(cu == "A" || cu == "C" || cu == "G" || cu == "T");
      code = bad ? 2'd0 : ch[2:1];
      if (seen_n >= win_len) begin
        old = bases[win_len-1];
        old_code = old[1:0];
        if (old[2] && bad_n != 0) bad_n--;
        fwd_h = rot_left(fwd_h, 1) ^ rot_left(ROLL_SEED[old_code], win_len) ^ ROLL_SEED[code];
        rev_h = rot_left(rev_h, 63) ^ rot_left(ROLL_SEED[old_code ^ 2'd2], 63)
              ^ rot_left(ROLL_SEED[code ^ 2'd2], win_len - 1);
      end else begin
        fwd_h = rot_left(fwd_h, 1) ^ ROLL_SEED[code];
        rev_h = rev_h ^ rot_left(ROLL_SEED[code ^ 2'd2], seen_n);
        seen_n++;
      end
      for (int i = 31; i > 0; i--) bases[i] = bases[i-1];
      bases[0] = {bad, code};
      if (bad) bad_n++;
      if (seen_n >= win_len && bad_n == 0) begin
        h = (fwd_h < rev_h) ? fwd_h : rev_h;
        h = seeded_fmix(h);
        if (double_fmix != 0) h = seeded_fmix(h);
        r.key = h[63:11];
        r.key_valid = 1'b1;
        r.inserted = add_key(r.key);
      end
      if (last) restart_rolling();
    end else if (op == kbks_pkg::OP_HASH) begin
      h = seeded_fmix(hv);
      r.key = h[63:11];
      r.key_valid = 1'b1;
      r.inserted = add_key(r.key);
    end else if (op == kbks_pkg::OP_READ) begin
      if (idx < kept_n) begin
        r.entry_valid = 1'b1;
        r.entry_value = kept_keys[idx];
      end
    end
    r.fill_count = 11'(kept_n);
    r.sketch_full = (kept_n == keep_count);
    r.cutoff_key = r.sketch_full ? kept_cutoff : '0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle);
  end

  // Prediction at acceptance and comparison against the oldest expected word.
  always @(posedge clk_i) begin
    sketch_res_t want, got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = sketch_step(opcode_i, base_char_i, last_in_sequence_i, hash_value_i,
                         entry_index_i);
      expected_words.push_back(typed_pending ? typed_word : want);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{key_valid_o, key_o, inserted_o, fill_count_o, sketch_full_o, cutoff_key_o,
              entry_valid_o, entry_value_o};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got.key_valid !== want.key_valid || got.key !== want.key ||
            got.inserted !== want.inserted || got.fill_count !== want.fill_count ||
            got.sketch_full !== want.sketch_full || got.cutoff_key !== want.cutoff_key ||
            got.entry_valid !== want.entry_valid || got.entry_value !== want.entry_value) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp kv=%0d key=%h ins=%0d fill=%0d full=%0d cut=%h ev=%0d ent=%h",
                     want.key_valid, want.key, want.inserted, want.fill_count,
                     want.sketch_full, want.cutoff_key, want.entry_valid, want.entry_value);
            $display("         got kv=%0d key=%h ins=%0d fill=%0d full=%0d cut=%h ev=%0d ent=%h",
                     got.key_valid, got.key, got.inserted, got.fill_count,
                     got.sketch_full, got.cutoff_key, got.entry_valid, got.entry_value);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      wd_count <= 0;
    end else if (wd_count >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic last, logic [63:0] hv,
                           logic [9:0] idx, logic typed, sketch_res_t res);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    base_char_i <= ch;
    last_in_sequence_i <= last;
    hash_value_i <= hv;
    entry_index_i <= idx;
    typed_pending <= typed;
    typed_word <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_base();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = "A";
      1: c = "C";
      2: c = "G";
      default: c = "T";
    endcase
    return $urandom_range(1) ? (c | 8'h20) : c;
  endfunction

  // Mostly long runs of well-formed bases, with hashes, reads and some noise mixed in.
  task automatic random_words(int count);
    int          r;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic        last;
    logic [63:0] hv;
    logic [9:0]  idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      hv = {$urandom, $urandom};
      idx = 10'($urandom);
      last = ($urandom_range(39) == 0);
      ch = pick_base();
      op = kbks_pkg::OP_BASE;
      if (r < 3) begin
        ch = 8'($urandom);
      end else if (r < 72) begin
        op = kbks_pkg::OP_BASE;
      end else if (r < 84) begin
        op = kbks_pkg::OP_HASH;
        last = 1'($urandom);
      end else if (r < 96) begin
        op = kbks_pkg::OP_READ;
        last = 1'($urandom);
        if (r < 93) idx = 10'($urandom_range(kept_n + 1));
      end else begin
        op = 2'($urandom);
        ch = 8'($urandom);
      end
      send_word(op, ch, last, hv, idx, 1'b0, '0);
      if (n == count / 2) drain();
    end
  endtask

  stim_row_t directed [23] = '{
    '{kbks_pkg::OP_READ, 8'h00, 1'b0, 64'h0, 10'd0, 1'b1, '0},
    '{OP_UNUSED, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 1'b1, '0},
    '{kbks_pkg::OP_READ, 8'h00, 1'b1, 64'h0, 10'h3FF, 1'b1, '0},
    '{kbks_pkg::OP_BASE, "A", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "c", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "G", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "t", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "N", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "a", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "g", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "C", 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, "T", 1'b1, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, 8'h00, 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_BASE, 8'hFF, 1'b1, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_HASH, 8'h00, 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_HASH, 8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_HASH, 8'h00, 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_HASH, 8'h00, 1'b0, 64'h0123_4567_89AB_CDEF, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_HASH, 8'h00, 1'b0, 64'h8000_0000_0000_0001, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_READ, 8'h00, 1'b0, 64'h0, 10'd0, 1'b0, '0},
    '{kbks_pkg::OP_READ, 8'h00, 1'b0, 64'h0, 10'd3, 1'b0, '0},
    '{kbks_pkg::OP_READ, 8'h00, 1'b0, 64'h0, 10'h3FF, 1'b0, '0},
    '{OP_UNUSED, 8'h41, 1'b0, 64'h0, 10'd0, 1'b0, '0}
  };

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= kbks_pkg::CFG_KMER;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= kbks_pkg::OP_BASE;
    base_char_i <= '0;
    last_in_sequence_i <= 1'b0;
    hash_value_i <= '0;
    entry_index_i <= '0;
    typed_pending <= 1'b0;
    typed_word <= '0;
    tx_idle = 24;
    rx_idle = 47;
    mismatches = 0;
    wd_count = 0;
    win_len = 21;
    keep_count = 1024;
    fmix_seed = '0;
    double_fmix = 1;
    kept_n = 0;
    kept_cutoff = '0;
    foreach (kept_keys[i]) kept_keys[i] = '0;
    foreach (bases[i]) bases[i] = '0;
    restart_rolling();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(kbks_pkg::CFG_KMER, 64'd3);
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd4);
    foreach (directed[i])
      send_word(directed[i].op, directed[i].ch, directed[i].last, directed[i].hash,
                directed[i].idx, directed[i].typed, directed[i].res);

    write_reg(kbks_pkg::CFG_KMER, 64'd5);
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd16);
    write_reg(kbks_pkg::CFG_SEED, {$urandom, $urandom});
    write_reg(kbks_pkg::CFG_DOUBLE, 64'd1);
    random_words(450);

    tx_idle = 47;
    rx_idle = 24;
    write_reg(kbks_pkg::CFG_KMER, 64'd32);
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd0);
    write_reg(kbks_pkg::CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(kbks_pkg::CFG_DOUBLE, 64'd0);
    random_words(300);
    write_reg(kbks_pkg::CFG_KMER, 64'd63);
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd2047);
    random_words(60);

    tx_idle = 0;
    rx_idle = 0;
    write_reg(kbks_pkg::CFG_KMER, 64'd1);
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd40);
    write_reg(kbks_pkg::CFG_SEED, 64'd0);
    write_reg(kbks_pkg::CFG_DOUBLE, 64'd1);
    random_words(320);
    // Shrinking the store below its fill drops the largest keys.
    write_reg(kbks_pkg::CFG_ENTRIES, 64'd2);
    write_reg(kbks_pkg::CFG_KMER, 64'd0);
    random_words(100);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* kmer_bottom_k_sketch.f */
hdl/kbks_pkg.sv
hdl/kbks_fmix.sv
hdl/kbks_store.sv
hdl/kmer_bottom_k_sketch.sv
verif/tb_top.sv
